@@ src/eabv_pkg.sv @@
package eabv_pkg;

   localparam int ANG_W     = 16;
   localparam int OUT_W     = 16;
   localparam int Q_W       = 34;
   localparam int ATAN_N    = 24;
   localparam int TURN      = 23040;
   localparam int QUARTER   = 5760;
   localparam logic signed [Q_W-1:0] INV_GAIN = 34'sd652032874;

   typedef logic signed [Q_W-1:0] q30_type;

   typedef struct packed {
      q30_type x;
      q30_type y;
      q30_type z;
      logic [1:0] quad;
   } rot_type;

   function automatic q30_type atan_q30(input int i);
      q30_type r;
      case (i)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd67021687;
         5: r = 34'sd33543515;
         6: r = 34'sd16775850;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         16: r = 34'sd16383;
         17: r = 34'sd8191;
         18: r = 34'sd4095;
         19: r = 34'sd2047;
         20: r = 34'sd1023;
         21: r = 34'sd511;
         22: r = 34'sd255;
         23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ src/eabv_cell.sv @@
module eabv_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  eabv_pkg::rot_type in_data,
   output eabv_pkg::rot_type out_ff
);
   import eabv_pkg::*;

   rot_type out_in;
   q30_type xs, ys;

   assign xs = in_data.x >>> STAGE;
   assign ys = in_data.y >>> STAGE;

   always_comb begin
      out_in = in_data;
      if (!in_data.z[Q_W-1]) begin
         out_in.x = in_data.x - ys;
         out_in.y = in_data.y + xs;
         out_in.z = in_data.z - atan_q30(STAGE);
      end else begin
         out_in.x = in_data.x + ys;
         out_in.y = in_data.y - xs;
         out_in.z = in_data.z + atan_q30(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end
endmodule

@@ src/eabv_trig.sv @@
module eabv_trig #(
   parameter int TRIG_STAGES = 16
) (
   input  logic                    clock,
   input  logic signed [15:0]      angle,
   output eabv_pkg::q30_type       sin_ff,
   output eabv_pkg::q30_type       cos_ff
);
   import eabv_pkg::*;

   localparam int N = (TRIG_STAGES > ATAN_N) ? ATAN_N : TRIG_STAGES;

   // reduction, stage a: wrap into one turn
   logic [14:0] r_ff, r_in;
   logic signed [17:0] a3;
   always_comb begin
      a3 = 18'(angle) + 18'sd69120;
      if (a3 >= 18'sd92160)      r_in = 15'(a3 - 18'sd92160);
      else if (a3 >= 18'sd69120) r_in = 15'(a3 - 18'sd69120);
      else if (a3 >= 18'sd46080) r_in = 15'(a3 - 18'sd46080);
      else                       r_in = 15'(a3 - 18'sd23040);
   end

   // stage b: quadrant and centered remainder
   logic [1:0] q_ff, q_in;
   logic signed [13:0] f_ff, f_in;
   logic [12:0] fr;
   always_comb begin
      if (r_ff >= 15'd17280)      begin q_in = 2'd3; fr = 13'(r_ff - 15'd17280); end
      else if (r_ff >= 15'd11520) begin q_in = 2'd2; fr = 13'(r_ff - 15'd11520); end
      else if (r_ff >= 15'd5760)  begin q_in = 2'd1; fr = 13'(r_ff - 15'd5760);  end
      else                        begin q_in = 2'd0; fr = 13'(r_ff);             end
      f_in = $signed({1'b0, fr});
      if (fr >= 13'd2880) begin
         f_in = $signed({1'b0, fr}) - 14'sd5760;
         q_in = q_in + 2'd1;
      end
   end

   // stage c: magnitude times pi
   logic [43:0] p_ff;
   logic [11:0] m;
   logic neg_ff;
   logic [1:0] q2_ff;
   assign m = f_ff[13] ? 12'(-f_ff) : 12'(f_ff);

   // stage d: divide by 11520 as shift by 8 then divide by 45 via reciprocal
   logic [43:0] pr;
   logic [35:0] t, t_ff;
   logic [31:0] est, est_ff;
   logic [1:0] q3_ff;
   logic neg2_ff;
   assign pr = p_ff + 44'd5760;
   // floor(pr/11520): pr < 2^44; t = pr>>8 < 2^36, then /45
   assign t = pr[43:8];
   always_comb begin
      logic [69:0] prod;
      prod = 70'(t) * 70'd1527099483;   // floor(2^36/45), estimate low by at most one
      est = 32'(prod >> 36);
   end

   // stage e: fix up the quotient estimate
   logic [31:0] zq_ff, zq_in;
   logic [35:0] rem;
   logic [1:0] q4_ff;
   logic neg3_ff;
   always_comb begin
      rem = t_ff - 36'(est_ff) * 36'd45;
      zq_in = (rem >= 36'd45) ? est_ff + 32'd1 : est_ff;
   end

   rot_type chain [0:N];

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      q_ff    <= q_in;
      f_ff    <= f_in;
      p_ff    <= 44'(m) * 44'd3373259426;
      neg_ff  <= f_ff[13];
      q2_ff   <= q_ff;
      t_ff    <= t;
      est_ff  <= est;
      neg2_ff <= neg_ff;
      q3_ff   <= q2_ff;
      zq_ff   <= zq_in;
      neg3_ff <= neg2_ff;
      q4_ff   <= q3_ff;
   end

   always_comb begin
      chain[0].x = INV_GAIN;
      chain[0].y = '0;
      chain[0].z = neg3_ff ? -q30_type'(zq_ff) : q30_type'(zq_ff);
      chain[0].quad = q4_ff;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      eabv_cell #(.STAGE(i)) u_cell (
         .clock(clock), .in_data(chain[i]), .out_ff(chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      case (chain[N].quad)
         2'd0: begin sin_ff <= chain[N].y;  cos_ff <= chain[N].x;  end
         2'd1: begin sin_ff <= chain[N].x;  cos_ff <= -chain[N].y; end
         2'd2: begin sin_ff <= -chain[N].y; cos_ff <= -chain[N].x; end
         default: begin sin_ff <= -chain[N].x; cos_ff <= chain[N].y; end
      endcase
   end
endmodule

@@ src/euler_angles_to_basis_vectors.sv @@
// channel | ports                       | dir | handshake
// req     | req_pitch/yaw/roll_deg      | in  | start & !busy
// rsp     | rsp_fwd_*, rsp_right_*, ... | out | rsp_valid, one cycle
// one beat accepted per cycle; busy is always low
// rsp_valid rises together with the results, after the request has passed through:
// 5 reduction stages, the cordic cell row, quadrant swap, 2 product stages, output round
// reset clears only the valid pipeline; the receiver cannot stall
module euler_angles_to_basis_vectors #(
   parameter int TRIG_STAGES   = 16,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_pitch_deg,
   input  logic signed [15:0] req_yaw_deg,
   input  logic signed [15:0] req_roll_deg,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_fwd_x,
   output logic signed [15:0] rsp_fwd_y,
   output logic signed [15:0] rsp_fwd_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z
);
   import eabv_pkg::*;

   localparam int N   = (TRIG_STAGES > ATAN_N) ? ATAN_N : TRIG_STAGES;
   localparam int FB  = (OUT_FRAC_BITS > 30) ? 30 : OUT_FRAC_BITS;
   localparam int SH  = 30 - FB;
   localparam int LAT = N + 9;

   assign busy = 1'b0;

   q30_type sp, cp, sy, cy, sr, cr;
   eabv_trig #(.TRIG_STAGES(TRIG_STAGES)) u_p (.clock(clock), .angle(req_pitch_deg),
      .sin_ff(sp), .cos_ff(cp));
   eabv_trig #(.TRIG_STAGES(TRIG_STAGES)) u_y (.clock(clock), .angle(req_yaw_deg),
      .sin_ff(sy), .cos_ff(cy));
   eabv_trig #(.TRIG_STAGES(TRIG_STAGES)) u_r (.clock(clock), .angle(req_roll_deg),
      .sin_ff(sr), .cos_ff(cr));

   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return q30_type'(p >>> 30);
   endfunction

   function automatic logic signed [15:0] emit(input logic signed [35:0] v);
      logic signed [35:0] w;
      w = v;
      if (SH > 0) w = (v + (36'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      if (w > 36'sd32767) return 16'sh7fff;
      if (w < -36'sd32768) return 16'sh8000;
      return 16'(w);
   endfunction

   // product stage 1
   q30_type srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff, srsy_ff, srcy_ff;
   q30_type srcp_ff, crcp_ff, sp1_ff, cy1_ff, sy1_ff;
   always_ff @(posedge clock) begin
      srsp_ff <= mul30(sr, sp);  crsp_ff <= mul30(cr, sp);
      cpcy_ff <= mul30(cp, cy);  cpsy_ff <= mul30(cp, sy);
      crsy_ff <= mul30(cr, sy);  crcy_ff <= mul30(cr, cy);
      srsy_ff <= mul30(sr, sy);  srcy_ff <= mul30(sr, cy);
      srcp_ff <= mul30(sr, cp);  crcp_ff <= mul30(cr, cp);
      sp1_ff <= sp; cy1_ff <= cy; sy1_ff <= sy;
   end

   // product stage 2
   q30_type a_ff, b_ff, c_ff, d_ff;
   q30_type cpcy2_ff, cpsy2_ff, sp2_ff, crsy2_ff, crcy2_ff, srsy2_ff, srcy2_ff;
   q30_type srcp2_ff, crcp2_ff;
   always_ff @(posedge clock) begin
      a_ff <= mul30(srsp_ff, cy1_ff); b_ff <= mul30(srsp_ff, sy1_ff);
      c_ff <= mul30(crsp_ff, cy1_ff); d_ff <= mul30(crsp_ff, sy1_ff);
      cpcy2_ff <= cpcy_ff; cpsy2_ff <= cpsy_ff; sp2_ff <= sp1_ff;
      crsy2_ff <= crsy_ff; crcy2_ff <= crcy_ff; srsy2_ff <= srsy_ff;
      srcy2_ff <= srcy_ff; srcp2_ff <= srcp_ff; crcp2_ff <= crcp_ff;
   end

   always_ff @(posedge clock) begin
      rsp_fwd_x   <= emit(36'(cpcy2_ff));
      rsp_fwd_y   <= emit(36'(cpsy2_ff));
      rsp_fwd_z   <= emit(-36'(sp2_ff));
      rsp_right_x <= emit(-36'(a_ff) + 36'(crsy2_ff));
      rsp_right_y <= emit(-36'(b_ff) - 36'(crcy2_ff));
      rsp_right_z <= emit(-36'(srcp2_ff));
      rsp_up_x    <= emit(36'(c_ff) + 36'(srsy2_ff));
      rsp_up_y    <= emit(36'(d_ff) - 36'(srcy2_ff));
      rsp_up_z    <= emit(36'(crcp2_ff));
   end

   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];
endmodule

@@ src/eabv_checker.sv @@
module eabv_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic signed [15:0] rsp_fwd_z,
   input logic signed [15:0] rsp_up_z
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_idle_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
   a_upz_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fwd_z == 16'sh8000 |-> rsp_up_z != 16'sh7fff)
      else $error("pitch sine and cosine both full scale");
endmodule

bind euler_angles_to_basis_vectors eabv_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_fwd_z(rsp_fwd_z), .rsp_up_z(rsp_up_z)
);
